// ----- src/mbsd_pkg.sv -----
// Shared types and constants for the multiplexed button scan debouncer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mbsd_pkg;

    localparam int CHANNELS     = 16;
    localparam int POT_CHANNELS = 8;

    localparam int CHAN_W  = 4;
    localparam int LEVEL_W = 10;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;

    typedef enum logic
    {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic
    {
        CFG_THRESHOLD = 1'b0,
        CFG_INTERVAL  = 1'b1
    } cfg_index_t;

    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(512);
    localparam logic [COUNT_W-1:0] INTERVAL_RESET  = COUNT_W'(10);

    typedef struct packed
    {
        logic ok;
        logic pressed;
        logic just_pressed;
        logic just_released;
    } chan_res_t;

    typedef struct packed
    {
        logic               scan_due;
        logic [CHAN_W-1:0]  channel_out;
        logic               pressed;
        logic               just_pressed;
        logic               just_released;
        logic               pot_valid;
        logic [LEVEL_W-1:0] pot_value;
    } result_t;

endpackage

`default_nettype wire

// ----- src/mbsd_cfg_regs.sv -----
// Configuration registers: button threshold and scan interval.
// Depends on mbsd_pkg.
`default_nettype none

module mbsd_cfg_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [mbsd_pkg::CFG_W-1:0]  cfg_data,
    output logic      [mbsd_pkg::LEVEL_W-1:0] threshold,
    output logic      [mbsd_pkg::COUNT_W-1:0] interval
);
    import mbsd_pkg::*;

    logic [LEVEL_W-1:0] threshold_reg;
    logic [COUNT_W-1:0] interval_reg;
    logic               wr;

    assign wr = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            interval_reg  <= INTERVAL_RESET;
        end
        else if (wr)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD: threshold_reg <= cfg_data[LEVEL_W-1:0];
                CFG_INTERVAL:  interval_reg  <= cfg_data[COUNT_W-1:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    assign threshold = threshold_reg;
    assign interval  = interval_reg;

endmodule

`default_nettype wire

// ----- src/mbsd_tick.sv -----
// Tick counter that flags the end of each scan interval.
// Depends on mbsd_pkg.
`default_nettype none

module mbsd_tick
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         tick_en,
    input  wire logic [mbsd_pkg::COUNT_W-1:0] interval,
    output logic                              due
);
    import mbsd_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W:0]   elapsed;

    assign elapsed = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign due     = elapsed >= {1'b0, interval};

    always_comb
    begin
        count_next = count_reg;
        if (tick_en)
        begin
            count_next = due ? '0 : elapsed[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/mbsd_chan_state.sv -----
// Per-channel two-sample debounce state with one-shot press and release events.
// Depends on mbsd_pkg.
`default_nettype none

module mbsd_chan_state
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        sample_en,
    input  wire logic [mbsd_pkg::CHAN_W-1:0] channel,
    input  wire logic                        raw,
    output mbsd_pkg::chan_res_t              res
);
    import mbsd_pkg::*;

    logic [CHANNELS-1:0] last_raw_reg;
    logic [CHANNELS-1:0] last_raw_next;
    logic [CHANNELS-1:0] deb_reg;
    logic [CHANNELS-1:0] deb_next;
    logic                ok;
    logic                last_raw;
    logic                deb;
    logic                agree;
    logic                deb_new;

    assign ok       = 32'(channel) < CHANNELS;
    assign last_raw = ok ? last_raw_reg[channel] : 1'b0;
    assign deb      = ok ? deb_reg[channel] : 1'b0;
    assign agree    = raw == last_raw;
    assign deb_new  = agree ? !raw : deb;

    always_comb
    begin
        last_raw_next = last_raw_reg;
        deb_next      = deb_reg;
        if (sample_en && ok)
        begin
            last_raw_next[channel] = raw;
            deb_next[channel]      = deb_new;
        end
        res.ok            = ok;
        res.pressed       = ok && deb_new;
        res.just_pressed  = ok && agree && !deb && !raw;
        res.just_released = ok && agree && deb && raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= '0;
            deb_reg      <= '0;
        end
        else
        begin
            last_raw_reg <= last_raw_next;
            deb_reg      <= deb_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/mux_button_scan_debouncer.sv -----
// Button scan debouncer top level: input register, evaluation, result register.
// Depends on mbsd_pkg, mbsd_cfg_regs, mbsd_tick and mbsd_chan_state.
//
// Takes one request per clock while in_stall is low and returns exactly one result
// per request, in order, through one input register and one result register. A tick
// request advances the interval counter and raises scan_due when the interval has
// elapsed; a sample request compares the button level against the threshold and
// updates that channel's debounce state, a read-modify-write of two flip-flops per
// channel as the request advances, so back-to-back samples of the same channel need
// no stall. in_stall rises only while a result is held by out_stall and the input
// register is full. Configuration writes are always ready and should only be made
// while no request is in flight.
`default_nettype none

module mux_button_scan_debouncer
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         op,
    input  wire logic [mbsd_pkg::CHAN_W-1:0]  channel,
    input  wire logic [mbsd_pkg::LEVEL_W-1:0] button_level,
    input  wire logic [mbsd_pkg::LEVEL_W-1:0] pot_level,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              scan_due,
    output logic      [mbsd_pkg::CHAN_W-1:0]  channel_out,
    output logic                              pressed,
    output logic                              just_pressed,
    output logic                              just_released,
    output logic                              pot_valid,
    output logic      [mbsd_pkg::LEVEL_W-1:0] pot_value,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic                         cfg_index,
    input  wire logic [mbsd_pkg::CFG_W-1:0]   cfg_data
);
    import mbsd_pkg::*;

    logic               s0_valid_reg;
    logic               s0_valid_next;
    op_t                s0_op_reg;
    logic [CHAN_W-1:0]  s0_chan_reg;
    logic [LEVEL_W-1:0] s0_blevel_reg;
    logic [LEVEL_W-1:0] s0_plevel_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            res_reg;
    result_t            res_next;

    logic               advance;
    logic               accept;
    logic [LEVEL_W-1:0] threshold;
    logic [COUNT_W-1:0] interval;
    logic               due;
    logic               raw;
    chan_res_t          chan_res;

    assign cfg_ready = 1'b1;

    assign advance  = s0_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s0_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    mbsd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .threshold (threshold),
        .interval  (interval)
    );

    mbsd_tick u_tick
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick_en  (advance && (s0_op_reg == OP_TICK)),
        .interval (interval),
        .due      (due)
    );

    assign raw = s0_blevel_reg > threshold;

    mbsd_chan_state u_chan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_en (advance && (s0_op_reg == OP_SAMPLE)),
        .channel   (s0_chan_reg),
        .raw       (raw),
        .res       (chan_res)
    );

    always_comb
    begin
        res_next = '0;
        case (s0_op_reg)
            OP_TICK:
            begin
                res_next.scan_due = due;
            end
            OP_SAMPLE:
            begin
                res_next.channel_out   = s0_chan_reg;
                res_next.pressed       = chan_res.pressed;
                res_next.just_pressed  = chan_res.just_pressed;
                res_next.just_released = chan_res.just_released;
                res_next.pot_valid     = chan_res.ok && (32'(s0_chan_reg) < POT_CHANNELS);
                res_next.pot_value     = res_next.pot_valid ? s0_plevel_reg : '0;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (accept)
        begin
            s0_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s0_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_op_reg     <= op_t'(op);
            s0_chan_reg   <= channel;
            s0_blevel_reg <= button_level;
            s0_plevel_reg <= pot_level;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign scan_due      = res_reg.scan_due;
    assign channel_out   = res_reg.channel_out;
    assign pressed       = res_reg.pressed;
    assign just_pressed  = res_reg.just_pressed;
    assign just_released = res_reg.just_released;
    assign pot_valid     = res_reg.pot_valid;
    assign pot_value     = res_reg.pot_value;

    a_press_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && just_pressed |-> pressed && !just_released)
        else $error("press event without pressed state");

    a_release_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && just_released |-> !pressed)
        else $error("release event with pressed state");

    a_tick_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scan_due |-> channel_out == '0 && !pot_valid && !pressed)
        else $error("tick result carries sample fields");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back pressure");

    a_advance_fill: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced request produced no result");

endmodule

`default_nettype wire

// ----- test/mbsd_result_checker.sv -----
// Result checker for the button scan debouncer: mirrors the tick counter, the
// threshold compare and the per-channel debounce state, and compares every result.
// Depends on mbsd_pkg for the request codes, register indexes and result layout.
`timescale 1ns / 100ps

module mbsd_result_checker
    import mbsd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  op_t                     op,
    input  wire logic [CHAN_W-1:0]  channel,
    input  wire logic [LEVEL_W-1:0] button_level,
    input  wire logic [LEVEL_W-1:0] pot_level,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic               scan_due,
    input  wire logic [CHAN_W-1:0]  channel_out,
    input  wire logic               pressed,
    input  wire logic               just_pressed,
    input  wire logic               just_released,
    input  wire logic               pot_valid,
    input  wire logic [LEVEL_W-1:0] pot_value,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  cfg_index_t              cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    output int                      errors,
    output int                      pending
);

    logic [LEVEL_W-1:0]  threshold;
    logic [COUNT_W-1:0]  interval;
    logic [COUNT_W-1:0]  tick_total;
    logic [CHANNELS-1:0] prior_raw;
    logic [CHANNELS-1:0] held_press;
    result_t             owed_results[$];
    result_t             oldest;
    int                  mismatches = 0;

    function automatic result_t scan_result_of(op_t kind, logic [CHAN_W-1:0] ch,
                                               logic [LEVEL_W-1:0] blevel,
                                               logic [LEVEL_W-1:0] plevel);
        result_t          r;
        logic [COUNT_W:0] elapsed;
        logic             raw;
        r = '0;
        if (kind == OP_TICK)
        begin
            elapsed = {1'b0, tick_total} + 1'b1;
            if (elapsed >= {1'b0, interval})
            begin
                r.scan_due = 1'b1;
                tick_total = '0;
            end
            else
            begin
                tick_total = elapsed[COUNT_W-1:0];
            end
            return r;
        end
        r.channel_out = ch;
        if (int'(ch) >= CHANNELS)
            return r;
        raw = (blevel > threshold);
        if (raw == prior_raw[ch])
        begin
            if (!held_press[ch] && !raw)
                r.just_pressed = 1'b1;
            else if (held_press[ch] && raw)
                r.just_released = 1'b1;
            held_press[ch] = ~raw;
        end
        prior_raw[ch] = raw;
        r.pressed = held_press[ch];
        if (int'(ch) < POT_CHANNELS)
        begin
            r.pot_valid = 1'b1;
            r.pot_value = plevel;
        end
        return r;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got)
        begin
            if (mismatches < 50)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold  = THRESHOLD_RESET;
            interval   = INTERVAL_RESET;
            tick_total = '0;
            prior_raw  = '0;
            held_press = '0;
            owed_results.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    if (mismatches < 50)
                        $display("%0t: result with no request, expected none, actual channel %0d",
                                 $time, channel_out);
                    mismatches++;
                end
                else
                begin
                    oldest = owed_results.pop_front();
                    compare_field("scan_due", oldest.scan_due, scan_due);
                    compare_field("channel_out", oldest.channel_out, channel_out);
                    compare_field("pressed", oldest.pressed, pressed);
                    compare_field("just_pressed", oldest.just_pressed, just_pressed);
                    compare_field("just_released", oldest.just_released, just_released);
                    compare_field("pot_valid", oldest.pot_valid, pot_valid);
                    compare_field("pot_value", oldest.pot_value, pot_value);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_THRESHOLD)
                    threshold = cfg_data[LEVEL_W-1:0];
                else
                    interval = cfg_data[COUNT_W-1:0];
            end
            if (in_valid && !in_stall)
                owed_results.push_back(scan_result_of(op, channel, button_level, pot_level));
            pending <= owed_results.size();
            errors  <= mismatches;
        end
    end

endmodule

// ----- test/tb.sv -----
// Testbench top for mux_button_scan_debouncer: clock, reset, requests, register
// writes, random idling on both channels and the verdict.
// Depends on mbsd_pkg, the block and mbsd_result_checker.
`timescale 1ns / 100ps

module tb;
    import mbsd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    op_t                req_op       = OP_TICK;
    logic [CHAN_W-1:0]  req_channel  = '0;
    logic [LEVEL_W-1:0] req_button   = '0;
    logic [LEVEL_W-1:0] req_pot      = '0;
    logic               out_stall    = 1'b0;
    logic               cfg_valid    = 1'b0;
    cfg_index_t         cfg_index    = CFG_THRESHOLD;
    logic [CFG_W-1:0]   cfg_data     = '0;

    wire logic               in_stall;
    wire logic               out_valid;
    wire logic               scan_due;
    wire logic [CHAN_W-1:0]  channel_out;
    wire logic               pressed;
    wire logic               just_pressed;
    wire logic               just_released;
    wire logic               pot_valid;
    wire logic [LEVEL_W-1:0] pot_value;
    wire logic               cfg_ready;

    int                 errors;
    int                 pending;
    int                 gap_odds   = 0;
    int                 stall_odds = 0;
    int                 stall_left = 0;
    int unsigned        cycle_count = 0;
    logic [LEVEL_W-1:0] cur_threshold = THRESHOLD_RESET;

    mux_button_scan_debouncer uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (req_op),
        .channel       (req_channel),
        .button_level  (req_button),
        .pot_level     (req_pot),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scan_due      (scan_due),
        .channel_out   (channel_out),
        .pressed       (pressed),
        .just_pressed  (just_pressed),
        .just_released (just_released),
        .pot_valid     (pot_valid),
        .pot_value     (pot_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mbsd_result_checker results_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (req_op),
        .channel       (req_channel),
        .button_level  (req_button),
        .pot_level     (req_pot),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scan_due      (scan_due),
        .channel_out   (channel_out),
        .pressed       (pressed),
        .just_pressed  (just_pressed),
        .just_released (just_released),
        .pot_valid     (pot_valid),
        .pot_value     (pot_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // hold the result side in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_odds > 0 && $urandom_range(0, 99) < stall_odds)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 17);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic issue_request(op_t kind, logic [CHAN_W-1:0] ch,
                                 logic [LEVEL_W-1:0] blevel, logic [LEVEL_W-1:0] plevel);
        if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_op      <= kind;
        req_channel <= ch;
        req_button  <= blevel;
        req_pot     <= plevel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_registers(logic [LEVEL_W-1:0] thr, logic [COUNT_W-1:0] ticks);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= {6'($urandom), thr};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_INTERVAL;
        cfg_data  <= ticks;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        cur_threshold = thr;
    endtask

    function automatic logic [LEVEL_W-1:0] level_for(logic released, logic [LEVEL_W-1:0] thr);
        if (released)
        begin
            if (thr == 10'd1023)
                return 10'($urandom);
            if ($urandom_range(0, 3) == 0)
                return thr + 10'd1;
            return 10'($urandom_range(int'(thr) + 1, 1023));
        end
        if ($urandom_range(0, 3) == 0)
            return thr;
        return 10'($urandom_range(0, int'(thr)));
    endfunction

    task automatic random_traffic(int count);
        int                made;
        int                pick;
        int                reps;
        logic [CHAN_W-1:0] ch;
        logic              released;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                issue_request(OP_TICK, 4'($urandom), 10'($urandom), 10'($urandom));
                made++;
            end
            else if (pick < 85)
            begin
                // hold one raw level on one channel for a run of samples
                ch       = 4'($urandom);
                released = 1'($urandom);
                reps     = $urandom_range(1, 3);
                repeat (reps)
                begin
                    issue_request(OP_SAMPLE, ch, level_for(released, cur_threshold),
                                  10'($urandom));
                    made++;
                end
            end
            else
            begin
                issue_request(OP_SAMPLE, 4'($urandom), 10'($urandom), 10'($urandom));
                made++;
            end
        end
    endtask

    initial
    begin
        logic [LEVEL_W-1:0] thr;
        logic [COUNT_W-1:0] ticks;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(OP_SAMPLE, 4'd0, 10'd0, 10'd1023);
        issue_request(OP_SAMPLE, 4'd0, 10'd1023, 10'd0);
        issue_request(OP_SAMPLE, 4'd0, 10'd1023, 10'd0);
        issue_request(OP_SAMPLE, 4'd7, 10'd512, 10'h2AA);
        issue_request(OP_SAMPLE, 4'd7, 10'd513, 10'h155);
        issue_request(OP_SAMPLE, 4'd7, 10'd513, 10'h155);
        issue_request(OP_SAMPLE, 4'd8, 10'd1023, 10'd1023);
        issue_request(OP_SAMPLE, 4'd8, 10'd1023, 10'd1023);
        issue_request(OP_SAMPLE, 4'd15, 10'd0, 10'd1023);
        issue_request(OP_SAMPLE, 4'd15, 10'd0, 10'd0);
        repeat (11) issue_request(OP_TICK, 4'd0, 10'd0, 10'd0);
        issue_request(OP_SAMPLE, 4'd5, 10'h155, 10'h155);
        issue_request(OP_SAMPLE, 4'd10, 10'h2AA, 10'h2AA);

        for (int phase = 0; phase < 8; phase++)
        begin
            drain_results();
            case (phase)
                0: begin thr = 10'd0;    ticks = 16'd1;     end
                1: begin thr = 10'd1023; ticks = 16'hFFFF;  end
                2: begin thr = 10'd512;  ticks = 16'd0;     end
                3: begin thr = 10'd300;  ticks = 16'd3;     end
                default:
                begin
                    thr   = 10'($urandom);
                    ticks = 16'($urandom_range(1, 40));
                end
            endcase
            program_registers(thr, ticks);
            case (phase)
                0: begin gap_odds <= 20; stall_odds <= 15; end
                1: begin gap_odds <= 0;  stall_odds <= 0;  end
                2: begin gap_odds <= 40; stall_odds <= 40; end
                3: begin gap_odds <= 10; stall_odds <= 5;  end
                4: begin gap_odds <= 60; stall_odds <= 0;  end
                5: begin gap_odds <= 5;  stall_odds <= 60; end
                6: begin gap_odds <= 30; stall_odds <= 20; end
                default: begin gap_odds <= 0; stall_odds <= 0; end
            endcase
            random_traffic(250);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
